// File: hw/rtl/stdmx_pkg.sv
// ----------------------------------------------------------------------------
// Surround to stereo downmix package
// Shared item types, fixed-point formats and constants of the downmix.
// ----------------------------------------------------------------------------
package stdmx_pkg;

  localparam int NUM_LANES = 5;
  localparam int LANE_W = 3;

  localparam logic [LANE_W-1:0] LANE_FL = 3'd0;
  localparam logic [LANE_W-1:0] LANE_FR = 3'd1;
  localparam logic [LANE_W-1:0] LANE_C  = 3'd2;
  localparam logic [LANE_W-1:0] LANE_SL = 3'd3;
  localparam logic [LANE_W-1:0] LANE_SR = 3'd4;

  localparam int FRAC_BITS = 40;
  localparam int IN_LIMIT_LOG2 = 16;
  localparam int MAG_W = IN_LIMIT_LOG2 + FRAC_BITS + 1;
  localparam int FIX_W = MAG_W + 1;
  localparam int ACC_W = 62;
  localparam int MIX_SHIFT = 42;
  localparam int MIX_MAG_W = MIX_SHIFT + 1;
  localparam int PCM_SHIFT = 15;
  localparam int PROD_W = MIX_MAG_W + PCM_SHIFT;
  localparam int PCM_W = 16;

  localparam logic [MAG_W-1:0] IN_LIMIT = {1'b1, {(MAG_W-1){1'b0}}};
  localparam logic [7:0] EXP_SPECIAL = 8'hFF;
  localparam logic [7:0] K_BIAS = 8'd110;
  localparam logic [7:0] MAX_LSHIFT = 8'd33;
  localparam logic [7:0] MAX_RSHIFT = 8'd24;

  typedef logic signed [FIX_W-1:0] fix_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  localparam acc_t MIX_ONE = acc_t'(1) <<< MIX_SHIFT;

  typedef struct packed {
    logic [31:0] front_left;
    logic [31:0] front_right;
    logic [31:0] center;
    logic [31:0] surround_left;
    logic [31:0] surround_right;
  } in_item_t;

  typedef struct packed {
    logic signed [PCM_W-1:0] left_sample;
    logic signed [PCM_W-1:0] right_sample;
  } out_item_t;

  typedef struct packed {
    logic                 neg;
    logic [MIX_MAG_W-1:0] mag;
  } mix_t;

endpackage

// File: hw/rtl/surround_to_stereo_s16_downmix.sv
// ----------------------------------------------------------------------------
// Surround to stereo downmix, 16-bit output
// Mixes five single-precision channels to clamped stereo 16-bit PCM.
// ----------------------------------------------------------------------------
// The block takes one sample instant in every clock cycle and never raises
// busy. Each item's result appears on out_data with out_strobe high once it
// has passed the registers of the five conversion lanes, the merge and clamp
// stage and the output scaler, in that order. The receiver must take every
// result in the cycle that it is shown.
module surround_to_stereo_s16_downmix import stdmx_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_data,
  output logic      out_strobe,
  output out_item_t out_data
);

  logic [31:0] lane_bits [NUM_LANES];
  fix_t        lane_fix  [NUM_LANES];
  mix_t        left_mix;
  mix_t        right_mix;
  logic [2:0]  vld_r;
  logic [2:0]  vld_nxt;

  assign busy = 1'b0;

  assign lane_bits[LANE_FL] = in_data.front_left;
  assign lane_bits[LANE_FR] = in_data.front_right;
  assign lane_bits[LANE_C]  = in_data.center;
  assign lane_bits[LANE_SL] = in_data.surround_left;
  assign lane_bits[LANE_SR] = in_data.surround_right;

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    stdmx_lane u_lane (
      .clk     (clk),
      .bits_in (lane_bits[i]),
      .fix_r   (lane_fix[i])
    );
  end

  stdmx_merge u_merge (
    .clk      (clk),
    .lane_fix (lane_fix),
    .left_r   (left_mix),
    .right_r  (right_mix)
  );

  stdmx_scale u_scale (
    .clk       (clk),
    .left_mix  (left_mix),
    .right_mix (right_mix),
    .data_r    (out_data)
  );

  assign vld_nxt = {vld_r[1:0], start & ~busy};
  assign out_strobe = vld_r[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_strobe)
    else $error("accepted item did not produce a result after three cycles");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_data.left_sample != 16'sh8000 &&
                    out_data.right_sample != 16'sh8000))
    else $error("result sample outside the clamped range");

  a_sign: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[1] && !left_mix.neg) |=> (out_data.left_sample >= 0))
    else $error("left result sign does not follow the mix");

endmodule

// File: hw/rtl/stdmx_lane.sv
// ----------------------------------------------------------------------------
// Downmix input lane
// Converts one single-precision pattern to saturating signed fixed point.
// ----------------------------------------------------------------------------
module stdmx_lane import stdmx_pkg::*; (
  input  logic        clk,
  input  logic [31:0] bits_in,
  output fix_t        fix_r
);

  logic             sgn;
  logic [7:0]       ex;
  logic [22:0]      man;
  logic [23:0]      full;
  logic [7:0]       e_eff;
  logic [7:0]       lsh;
  logic [7:0]       rsh;
  logic [MAG_W-1:0] shl;
  logic [MAG_W-1:0] mag;
  fix_t             fix_nxt;

  always_comb begin
    sgn   = bits_in[31];
    ex    = bits_in[30:23];
    man   = bits_in[22:0];
    full  = {(ex != 8'd0), man};
    e_eff = (ex == 8'd0) ? 8'd1 : ex;
    lsh   = e_eff - K_BIAS;
    rsh   = K_BIAS - e_eff;
    shl   = {{(MAG_W-24){1'b0}}, full} << lsh[5:0];
    mag   = '0;
    if (ex == EXP_SPECIAL) begin
      mag = (man == 23'd0) ? IN_LIMIT : '0;
    end else if (e_eff >= K_BIAS) begin
      if (lsh > MAX_LSHIFT) begin
        mag = IN_LIMIT;
      end else begin
        mag = (shl > IN_LIMIT) ? IN_LIMIT : shl;
      end
    end else begin
      mag = (rsh >= MAX_RSHIFT) ? '0 : {{(MAG_W-24){1'b0}}, full >> rsh[4:0]};
    end
    fix_nxt = sgn ? -fix_t'({1'b0, mag}) : fix_t'({1'b0, mag});
  end

  always_ff @(posedge clk) begin
    fix_r <= fix_nxt;
  end

endmodule

// File: hw/rtl/stdmx_merge.sv
// ----------------------------------------------------------------------------
// Downmix merge stage
// Combines the five lanes into left and right mixes and clamps them.
// ----------------------------------------------------------------------------
module stdmx_merge import stdmx_pkg::*; (
  input  logic clk,
  input  fix_t lane_fix [NUM_LANES],
  output mix_t left_r,
  output mix_t right_r
);

  acc_t sum_l;
  acc_t sum_r;
  acc_t ctr3;
  mix_t left_nxt;
  mix_t right_nxt;

  function automatic mix_t clamp_mix(input acc_t s);
    mix_t m;
    acc_t a;
    m.neg = (s < 0);
    a = m.neg ? -s : s;
    if (a > MIX_ONE) begin
      m.mag = MIX_ONE[MIX_MAG_W-1:0];
    end else begin
      m.mag = a[MIX_MAG_W-1:0];
    end
    return m;
  endfunction

  always_comb begin
    ctr3 = (acc_t'(lane_fix[LANE_C]) <<< 1) + acc_t'(lane_fix[LANE_C]);
    sum_l = (acc_t'(lane_fix[LANE_FL]) <<< 2) + ctr3 + (acc_t'(lane_fix[LANE_SL]) <<< 2);
    sum_r = (acc_t'(lane_fix[LANE_FR]) <<< 2) + ctr3 + (acc_t'(lane_fix[LANE_SR]) <<< 2);
    left_nxt = clamp_mix(sum_l);
    right_nxt = clamp_mix(sum_r);
  end

  always_ff @(posedge clk) begin
    left_r  <= left_nxt;
    right_r <= right_nxt;
  end

endmodule

// File: hw/rtl/stdmx_scale.sv
// ----------------------------------------------------------------------------
// Downmix output scaler
// Scales the clamped mixes by 32767 and truncates them to 16-bit PCM.
// ----------------------------------------------------------------------------
module stdmx_scale import stdmx_pkg::*; (
  input  logic      clk,
  input  mix_t      left_mix,
  input  mix_t      right_mix,
  output out_item_t data_r
);

  out_item_t data_nxt;

  function automatic logic signed [PCM_W-1:0] to_pcm(input mix_t m);
    logic [PROD_W-1:0] prod;
    logic [PCM_W-1:0]  q;
    prod = {m.mag, {PCM_SHIFT{1'b0}}} - {{PCM_SHIFT{1'b0}}, m.mag};
    q = prod[PROD_W-1:MIX_SHIFT];
    return m.neg ? -q : q;
  endfunction

  always_comb begin
    data_nxt.left_sample  = to_pcm(left_mix);
    data_nxt.right_sample = to_pcm(right_mix);
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule
